[hw/rtl/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int ONE = 1 << FB;
    // Radicand is at most ONE plus three full-scale diagonal terms.
    localparam int AW = DW + 1;
    localparam int XW = AW + FB + 1;
    localparam int RW = (XW + 1) / 2;
    localparam int NW = DW + 1;
    localparam int QW = DW;
    localparam int DEN_W = RW + 1;
    localparam int LW = DEN_W + QW + 1;
    localparam int SQ_STAGES = RW;
    localparam int DIV_STAGES = QW + 2;
    localparam int VD = 2 + SQ_STAGES + DIV_STAGES + 1;
    localparam int LANES = 3;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } t_mat;

    typedef struct packed {
        t_branch              br;
        logic signed [NW-1:0] n0;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
    } t_side;

    typedef struct packed {
        t_branch         br;
        logic [QW-1:0]   big;
        logic            fault;
    } t_tag;

    localparam logic [QW-1:0] POS_MAX = QW'((1 << (DW - 1)) - 1);
    localparam logic [QW-1:0] NEG_MAG = QW'(1 << (DW - 1));

    function automatic logic signed [DW-1:0] sat_q(input logic neg, input logic ovf,
                                                   input logic [QW-1:0] mag);
        logic signed [DW-1:0] res;
        if (!neg) begin
            res = (ovf || mag > POS_MAX) ? $signed(POS_MAX) : $signed(mag);
        end else if (ovf || mag > NEG_MAG) begin
            res = $signed(NEG_MAG);
        end else begin
            res = $signed(DW'(-mag));
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rmq_sqrt.sv]
`default_nettype none
module rmq_sqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_ce,
    input  wire logic [rmq_pkg::XW-1:0] i_x,
    input  rmq_pkg::t_side             i_side,
    output logic [rmq_pkg::RW-1:0]     o_root,
    output rmq_pkg::t_side             o_side
);
    import rmq_pkg::*;

    logic [XW-1:0] w_rem  [0:RW];
    logic [RW-1:0] w_root [0:RW];
    t_side         w_side [0:RW];
    logic [XW-1:0] r_rem  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];
    t_side         r_side [0:RW-1];

    assign w_rem[0]  = i_x;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    // One result bit per stage; the remainder holds x minus the root squared.
    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [XW+1:0] w_trial;
        logic [XW-1:0] n_rem;
        logic [RW-1:0] n_root;

        always_comb begin
            w_trial = ((XW + 2)'(w_root[k]) << (B + 1)) + ((XW + 2)'(1) << (2 * B));
            if ((XW + 2)'(w_rem[k]) >= w_trial) begin
                n_rem  = XW'((XW + 2)'(w_rem[k]) - w_trial);
                n_root = w_root[k] | (RW'(1) << B);
            end else begin
                n_rem  = w_rem[k];
                n_root = w_root[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_root = w_root[RW];
    assign o_side = w_side[RW];

endmodule
`default_nettype wire

[hw/rtl/rmq_div_lane.sv]
`default_nettype none
module rmq_div_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_ce,
    input  wire logic signed [rmq_pkg::NW-1:0] i_num,
    input  wire logic [rmq_pkg::RW-1:0]       i_root,
    output logic [rmq_pkg::QW-1:0]            o_mag,
    output logic                              o_ovf,
    output logic                              o_neg
);
    import rmq_pkg::*;

    logic [NW-1:0]    w_mag;
    logic             r_neg_p;
    logic [LW-1:0]    r_rem_p;
    logic [DEN_W-1:0] r_den_p;

    logic [LW-1:0]    w_rem [0:QW];
    logic [QW-1:0]    w_q   [0:QW];
    logic [DEN_W-1:0] w_den [0:QW];
    logic             w_neg [0:QW];
    logic             w_ovf [0:QW];
    logic [LW-1:0]    r_rem [0:QW];
    logic [QW-1:0]    r_q   [0:QW-1];
    logic [DEN_W-1:0] r_den [0:QW];
    logic             r_neg [0:QW];
    logic             r_ovf [0:QW];

    assign w_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    // Adding the root before dividing by twice the root rounds half away from zero.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_neg_p <= i_num[NW-1];
            r_rem_p <= (LW'(w_mag) << FB) + LW'(i_root);
            r_den_p <= {i_root, 1'b0};
        end
    end

    // A quotient of 2^QW or more saturates whatever the sign.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0] <= r_rem_p >= (LW'(r_den_p) << QW);
            r_rem[0] <= r_rem_p;
            r_den[0] <= r_den_p;
            r_neg[0] <= r_neg_p;
        end
    end

    assign w_rem[0] = r_rem[0];
    assign w_q[0]   = '0;
    assign w_den[0] = r_den[0];
    assign w_neg[0] = r_neg[0];
    assign w_ovf[0] = r_ovf[0];

    for (genvar j = 0; j < QW; j++) begin : g_bit
        localparam int B = QW - 1 - j;
        logic [LW-1:0] w_sub;
        logic [LW-1:0] n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            w_sub = LW'(w_den[j]) << B;
            if (w_rem[j] >= w_sub) begin
                n_rem = w_rem[j] - w_sub;
                n_q   = w_q[j] | (QW'(1) << B);
            end else begin
                n_rem = w_rem[j];
                n_q   = w_q[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j+1] <= n_rem;
                r_q[j]     <= n_q;
                r_den[j+1] <= w_den[j];
                r_neg[j+1] <= w_neg[j];
                r_ovf[j+1] <= w_ovf[j];
            end
        end

        assign w_rem[j+1] = r_rem[j+1];
        assign w_q[j+1]   = r_q[j];
        assign w_den[j+1] = r_den[j+1];
        assign w_neg[j+1] = r_neg[j+1];
        assign w_ovf[j+1] = r_ovf[j+1];
    end

    assign o_mag = w_q[QW];
    assign o_ovf = w_ovf[QW];
    assign o_neg = w_neg[QW];

endmodule
`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion.sv]
// A beat passes the matrix, radicand, root, divider and output registers; the root and the
// three divider lanes are fully pipelined and take one matrix per cycle while not stalled.
// The whole pipeline holds only while a result waits on the output and i_stall is high.
// Reset (i_rst_n low, synchronous) empties the pipeline; no clearing pass is needed.
`default_nettype none
module rotation_matrix_to_quaternion (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m00,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m01,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m02,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m10,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m11,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m12,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m20,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m21,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m22,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [rmq_pkg::DW-1:0]     o_quat_w,
    output logic signed [rmq_pkg::DW-1:0]     o_quat_x,
    output logic signed [rmq_pkg::DW-1:0]     o_quat_y,
    output logic signed [rmq_pkg::DW-1:0]     o_quat_z,
    output logic [1:0]                        o_branch_used,
    output logic                              o_div_fault
);
    import rmq_pkg::*;

    logic ce;
    logic r_vld [0:VD-1];

    t_mat  r_mat;
    t_side r_side;
    logic [XW-1:0] r_x;

    logic signed [DW+1:0] w_trace;
    logic signed [DW+2:0] w_rad;
    logic [AW-1:0]        w_a;
    t_branch              w_br;
    t_side                w_side;

    logic [RW-1:0] w_root;
    t_side         w_sq_side;
    t_tag          w_tag;
    t_tag          r_tag [0:DIV_STAGES-1];

    logic signed [NW-1:0] w_num [0:LANES-1];
    logic [QW-1:0]        w_mag [0:LANES-1];
    logic                 w_ovf [0:LANES-1];
    logic                 w_neg [0:LANES-1];
    logic signed [DW-1:0] w_q   [0:LANES-1];

    t_tag                 w_fin;
    logic signed [DW-1:0] w_big;
    logic signed [DW-1:0] n_w, n_x, n_y, n_z;
    logic signed [DW-1:0] r_w, r_x_q, r_y, r_z;
    t_branch              r_br;
    logic                 r_fault;

    assign ce      = !(r_vld[VD-1] && i_stall);
    assign o_stall = !ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VD; i++) r_vld[i] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < VD; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mat <= '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};
        end
    end

    // Branch choice: m11 wins over m00 and m22 over the current pick only when strictly larger.
    always_comb begin
        w_trace = (DW + 2)'(r_mat.m00) + (DW + 2)'(r_mat.m11) + (DW + 2)'(r_mat.m22);
        if (w_trace > 0) begin
            w_br = BR_TRACE;
        end else if (r_mat.m11 > r_mat.m00) begin
            w_br = (r_mat.m22 > r_mat.m11) ? BR_Z : BR_Y;
        end else begin
            w_br = (r_mat.m22 > r_mat.m00) ? BR_Z : BR_X;
        end

        w_side.br = w_br;
        unique case (w_br)
            BR_TRACE: begin
                w_rad = (DW + 3)'(w_trace) + (DW + 3)'(ONE);
                w_side.n0 = NW'(r_mat.m21) - NW'(r_mat.m12);
                w_side.n1 = NW'(r_mat.m02) - NW'(r_mat.m20);
                w_side.n2 = NW'(r_mat.m10) - NW'(r_mat.m01);
            end
            BR_X: begin
                w_rad = (DW + 3)'(ONE) + (DW + 3)'(r_mat.m00)
                      - (DW + 3)'(r_mat.m11) - (DW + 3)'(r_mat.m22);
                w_side.n0 = NW'(r_mat.m21) - NW'(r_mat.m12);
                w_side.n1 = NW'(r_mat.m01) + NW'(r_mat.m10);
                w_side.n2 = NW'(r_mat.m02) + NW'(r_mat.m20);
            end
            BR_Y: begin
                w_rad = (DW + 3)'(ONE) + (DW + 3)'(r_mat.m11)
                      - (DW + 3)'(r_mat.m00) - (DW + 3)'(r_mat.m22);
                w_side.n0 = NW'(r_mat.m02) - NW'(r_mat.m20);
                w_side.n1 = NW'(r_mat.m01) + NW'(r_mat.m10);
                w_side.n2 = NW'(r_mat.m12) + NW'(r_mat.m21);
            end
            default: begin
                w_rad = (DW + 3)'(ONE) + (DW + 3)'(r_mat.m22)
                      - (DW + 3)'(r_mat.m00) - (DW + 3)'(r_mat.m11);
                w_side.n0 = NW'(r_mat.m10) - NW'(r_mat.m01);
                w_side.n1 = NW'(r_mat.m02) + NW'(r_mat.m20);
                w_side.n2 = NW'(r_mat.m12) + NW'(r_mat.m21);
            end
        endcase
        w_a = w_rad[DW+2] ? '0 : w_rad[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x    <= XW'(w_a) << FB;
            r_side <= w_side;
        end
    end

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_x    (r_x),
        .i_side (r_side),
        .o_root (w_root),
        .o_side (w_sq_side)
    );

    assign w_tag.br    = w_sq_side.br;
    assign w_tag.big   = QW'(((RW + 1)'(w_root) + (RW + 1)'(1)) >> 1);
    assign w_tag.fault = (w_root == '0);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_tag[0] <= w_tag;
            for (int i = 1; i < DIV_STAGES; i++) r_tag[i] <= r_tag[i-1];
        end
    end

    assign w_num[0] = w_sq_side.n0;
    assign w_num[1] = w_sq_side.n1;
    assign w_num[2] = w_sq_side.n2;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        rmq_div_lane u_lane (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_num  (w_num[l]),
            .i_root (w_root),
            .o_mag  (w_mag[l]),
            .o_ovf  (w_ovf[l]),
            .o_neg  (w_neg[l])
        );
        assign w_q[l] = sat_q(w_neg[l], w_ovf[l], w_mag[l]);
    end

    // The lanes fill the three components other than the big one, in w, x, y, z order.
    always_comb begin
        w_fin = r_tag[DIV_STAGES-1];
        w_big = $signed(w_fin.big);
        unique case (w_fin.br)
            BR_TRACE: begin n_w = w_big; n_x = w_q[0]; n_y = w_q[1]; n_z = w_q[2]; end
            BR_X:     begin n_w = w_q[0]; n_x = w_big; n_y = w_q[1]; n_z = w_q[2]; end
            BR_Y:     begin n_w = w_q[0]; n_x = w_q[1]; n_y = w_big; n_z = w_q[2]; end
            default:  begin n_w = w_q[0]; n_x = w_q[1]; n_y = w_q[2]; n_z = w_big; end
        endcase
        if (w_fin.fault) begin
            n_w = '0;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_w     <= n_w;
            r_x_q   <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_br    <= w_fin.br;
            r_fault <= w_fin.fault;
        end
    end

    assign o_valid       = r_vld[VD-1];
    assign o_quat_w      = r_w;
    assign o_quat_x      = r_x_q;
    assign o_quat_y      = r_y;
    assign o_quat_z      = r_z;
    assign o_branch_used = r_br;
    assign o_div_fault   = r_fault;

endmodule
`default_nettype wire

[hw/rtl/rmq_checker.sv]
`default_nettype none
module rmq_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic signed [rmq_pkg::DW-1:0] o_quat_w,
    input wire logic signed [rmq_pkg::DW-1:0] o_quat_x,
    input wire logic signed [rmq_pkg::DW-1:0] o_quat_y,
    input wire logic signed [rmq_pkg::DW-1:0] o_quat_z,
    input wire logic [1:0]                   o_branch_used,
    input wire logic                         o_div_fault
);
    import rmq_pkg::*;

    // The input side only ever waits behind a result that is held up.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result waiting");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_fault) |->
        (o_quat_w == 0 && o_quat_x == 0 && o_quat_y == 0 && o_quat_z == 0))
        else $error("fault result carries non-zero components");

    a_trace_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_div_fault && o_branch_used == BR_TRACE) |-> o_quat_w > 0)
        else $error("trace branch gave a non-positive real part");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_quat_w) && $stable(o_quat_x)
        && $stable(o_quat_y) && $stable(o_quat_z) && $stable(o_branch_used)
        && $stable(o_div_fault)))
        else $error("stalled result beat changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
`default_nettype wire

[sim/rotation_matrix_to_quaternion_tb.sv]
`default_nettype none
module rotation_matrix_to_quaternion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int LATENCY = 37;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        t_branch              br;
        logic                 fault;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [DW-1:0] i_m00 = '0, i_m01 = '0, i_m02 = '0, i_m10 = '0, i_m11 = '0;
    logic signed [DW-1:0] i_m12 = '0, i_m20 = '0, i_m21 = '0, i_m22 = '0;
    logic signed [DW-1:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic [1:0] o_branch_used;
    logic o_div_fault;

    t_quat quat_due[$];
    int    fail_count = 0;
    longint cycle_count = 0;
    bit    hold_off = 1'b0;
    int    hold_cycles = 0;
    bit    stall_random = 1'b1;

    rotation_matrix_to_quaternion uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_m00, .i_m01, .i_m02, .i_m10, .i_m11, .i_m12, .i_m20, .i_m21, .i_m22,
        .o_valid, .i_stall,
        .o_quat_w, .o_quat_x, .o_quat_y, .o_quat_z, .o_branch_used, .o_div_fault
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Signed numerator over 2R, rounded to nearest with ties away from zero.
    function automatic longint ratio_over_s(longint n, longint unsigned r);
        longint unsigned mag = (n < 0) ? longint'(-n) : n;
        longint unsigned q = ((mag << FB) + r) / (2 * r);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [DW-1:0] clip(longint v);
        longint hi = (64'sd1 <<< (DW - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[DW-1:0];
    endfunction

    function automatic t_quat shepperd(t_mat m);
        t_quat q;
        longint a00 = m.m00, a01 = m.m01, a02 = m.m02, a10 = m.m10, a11 = m.m11;
        longint a12 = m.m12, a20 = m.m20, a21 = m.m21, a22 = m.m22;
        longint tr = a00 + a11 + a22;
        longint rad, big, w = 0, x = 0, y = 0, z = 0;
        longint unsigned r;
        t_branch br;
        if (tr > 0) begin
            br = BR_TRACE;
            rad = tr + ONE;
        end else begin
            br = BR_X;
            if (a11 > a00) br = BR_Y;
            if (a22 > ((br == BR_Y) ? a11 : a00)) br = BR_Z;
            case (br)
                BR_X: rad = ONE + a00 - a11 - a22;
                BR_Y: rad = ONE + a11 - a00 - a22;
                default: rad = ONE + a22 - a00 - a11;
            endcase
        end
        if (rad < 0) rad = 0;
        r = int_sqrt(longint'(rad) << FB);
        if (r != 0) begin
            big = (r + 1) >> 1;
            case (br)
                BR_TRACE: begin
                    w = big;
                    x = ratio_over_s(a21 - a12, r);
                    y = ratio_over_s(a02 - a20, r);
                    z = ratio_over_s(a10 - a01, r);
                end
                BR_X: begin
                    x = big;
                    y = ratio_over_s(a01 + a10, r);
                    z = ratio_over_s(a02 + a20, r);
                    w = ratio_over_s(a21 - a12, r);
                end
                BR_Y: begin
                    x = ratio_over_s(a01 + a10, r);
                    y = big;
                    z = ratio_over_s(a12 + a21, r);
                    w = ratio_over_s(a02 - a20, r);
                end
                default: begin
                    x = ratio_over_s(a02 + a20, r);
                    y = ratio_over_s(a12 + a21, r);
                    z = big;
                    w = ratio_over_s(a10 - a01, r);
                end
            endcase
        end
        q.w = clip(w);
        q.x = clip(x);
        q.y = clip(y);
        q.z = clip(z);
        q.br = br;
        q.fault = (r == 0);
        return q;
    endfunction

    // Receiver: random stall pattern, or a long counted hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else if (stall_random) begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (quat_due.size() == 0) begin
                $display("%0t: unexpected result beat w=%0d", $time, o_quat_w);
                fail_count++;
            end else begin
                exp_q = quat_due.pop_front();
                if (o_quat_w !== exp_q.w || o_quat_x !== exp_q.x || o_quat_y !== exp_q.y
                        || o_quat_z !== exp_q.z || o_branch_used !== exp_q.br
                        || o_div_fault !== exp_q.fault) begin
                    $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d br=%0d f=%0b",
                             $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br,
                             exp_q.fault);
                    $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d br=%0d f=%0b",
                             $time, o_quat_w, o_quat_x, o_quat_y, o_quat_z,
                             o_branch_used, o_div_fault);
                    fail_count++;
                end
            end
        end
    end

    int burst_left = 0;

    // Sends one matrix; gap cycles are taken between random bursts.
    task automatic send_matrix(t_mat m, bit gaps);
        int gap;
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        quat_due.push_back(shepperd(m));
    endtask

    task automatic end_send;
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        while (quat_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] rnd_elem();
        return DW'($urandom());
    endfunction

    function automatic t_mat rnd_matrix();
        t_mat m;
        m = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
             rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
        return m;
    endfunction

    // A near-rotation: small signed diagonal spread around one chosen axis.
    function automatic t_mat rotation_like();
        t_mat m;
        int sel = $urandom_range(0, 3);
        logic signed [DW-1:0] lo = -$signed(DW'($urandom_range(0, ONE)));
        m = rnd_matrix();
        m.m01 = DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
        m.m10 = DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
        m.m00 = (sel == 1) ? DW'(ONE) : lo;
        m.m11 = (sel == 2) ? DW'(ONE) : lo;
        m.m22 = (sel == 3) ? DW'(ONE) : lo;
        if (sel == 0) begin
            m.m00 = DW'($urandom_range(0, ONE));
            m.m11 = DW'($urandom_range(0, ONE));
            m.m22 = DW'($urandom_range(0, ONE));
        end
        return m;
    endfunction

    task automatic test_directed;
        logic signed [DW-1:0] mx = {1'b0, {(DW-1){1'b1}}};
        logic signed [DW-1:0] mn = {1'b1, {(DW-1){1'b0}}};
        logic signed [DW-1:0] one_q = DW'(ONE);
        logic signed [DW-1:0] z0 = '0;
        send_matrix('{one_q, z0, z0, z0, one_q, z0, z0, z0, one_q}, 0);
        send_matrix('{one_q, z0, z0, z0, -one_q, z0, z0, z0, -one_q}, 0);
        send_matrix('{-one_q, z0, z0, z0, one_q, z0, z0, z0, -one_q}, 0);
        send_matrix('{-one_q, z0, z0, z0, -one_q, z0, z0, z0, one_q}, 0);
        send_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 0);
        send_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn}, 0);
        send_matrix('{mn, mx, mn, mx, mn, mx, mn, mx, mn}, 0);
        send_matrix('{z0, mx, mn, mn, z0, mx, mx, mn, z0}, 0);
        // All diagonal ties at zero trace pick the first axis.
        send_matrix('{z0, one_q, z0, -one_q, z0, z0, z0, z0, z0}, 0);
        // Non-positive trace with m11 or m22 largest selects the y or z branch.
        send_matrix('{-one_q, mx, mx, mx, z0, mx, mx, mx, z0}, 0);
        send_matrix('{mn, one_q, one_q, one_q, z0, one_q, one_q, one_q, z0}, 0);
        send_matrix('{z0, z0, z0, z0, -one_q, z0, z0, z0, one_q}, 0);
        send_matrix('{-one_q, z0, z0, z0, z0, z0, z0, z0, z0}, 0);
        // Trace exactly zero is not positive; trace of one is.
        send_matrix('{16'sd1, z0, z0, z0, -16'sd1, z0, z0, z0, z0}, 0);
        send_matrix('{16'sd1, z0, z0, z0, z0, z0, z0, z0, z0}, 0);
        // Full-scale off-diagonal terms with the y branch chosen.
        send_matrix('{-16'sd16383, mx, mn, mn, z0, mx, mx, mn, z0}, 0);
        end_send();
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            send_matrix(($urandom_range(0, 3) == 0) ? rnd_matrix() : rotation_like(), 1);
        end
        end_send();
        wait_drained();
    endtask

    task automatic test_back_pressure;
        hold_off = 1'b1;
        hold_cycles = 0;
        fork
            begin
                while (hold_cycles < 3 * LATENCY) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 80; k++) send_matrix(rotation_like(), 0);
                end_send();
            end
        join
        wait_drained();
    endtask

    task automatic test_full_rate;
        stall_random = 1'b0;
        for (int k = 0; k < 100; k++) send_matrix(rnd_matrix(), 0);
        end_send();
        wait_drained();
        stall_random = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        test_back_pressure();
        test_full_rate();
        test_random(300);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && quat_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
